>>> hdl/hcm_pkg.sv
// ----------------------------------------------------------------------------
// hcm_pkg
// Shared sizes, types and command codes for the chained hash map.
// ----------------------------------------------------------------------------
`default_nettype none
package hcm_pkg;
    localparam int BUCKETS  = 1024;
    localparam int NODES    = 1024;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int NODE_W   = $clog2(NODES);
    localparam int KEY_W    = 64;
    localparam int CNT_W    = 11;
    localparam int LINK_W   = NODE_W + 1;
    localparam int STEP_W   = NODE_W + 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    typedef logic [KEY_W-1:0] word_t;
endpackage
`default_nettype wire

>>> hdl/chained_hash_map_top.sv
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset a clearing pass empties the bucket
// head RAM, with s_ready low. Check reads the bucket head it is given and
// skips the remainder unit. Insert and get first reduce the key modulo the
// bucket count in a bit-serial unit, read the bucket head, then walk the
// chain through node RAM one node at a time. s_ready returns in the same
// cycle as the result is raised; a result not yet taken holds the block in its
// final state. Throughput is set by the remainder unit and the chain length.
`default_nettype none
module chained_hash_map_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [hcm_pkg::CNT_W-1:0]  cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_command,
    input  wire logic signed [63:0]         s_key,
    input  wire logic signed [63:0]         s_value,
    input  wire logic [9:0]                 s_node_slot,
    input  wire logic [9:0]                 s_bucket,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_found,
    output logic signed [63:0]              m_read_value,
    output logic [9:0]                      m_node_used
);
    import hcm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_ROUTE = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_NRD   = 4'd4;
    localparam logic [3:0] S_NEV   = 4'd5;
    localparam logic [3:0] S_TWR   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_CLR   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    bcount_reg;
    logic [CNT_W-1:0]    active;
    logic [BUCKET_W-1:0] clr_reg, clr_next;
    logic [1:0]          cmd_reg, cmd_next;
    word_t               key_reg, key_next;
    word_t               val_reg, val_next;
    logic [9:0]          slot_reg, slot_next;
    logic [BUCKET_W-1:0] bkt_reg, bkt_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                nwr_reg, nwr_next;
    logic                rfound_reg, rfound_next;
    word_t               rval_reg, rval_next;
    logic [9:0]          rused_reg, rused_next;
    logic                mvalid_reg, mvalid_next;
    logic                mfound_reg, mfound_next;
    word_t               mval_reg, mval_next;
    logic [9:0]          mused_reg, mused_next;

    logic                div_start, div_busy, div_done;
    logic [CNT_W-1:0]    div_rem;
    logic                head_we;
    logic [BUCKET_W-1:0] head_waddr;
    logic [LINK_W-1:0]   head_wdata, head_rdata;
    logic                node_we;
    logic                link_we;
    logic [NODE_W-1:0]   link_waddr;
    logic [LINK_W-1:0]   link_wdata, link_rdata;
    word_t               key_rdata, val_rdata;
    logic                slot_ok;

    always_comb begin
        active = bcount_reg;
        if (bcount_reg == '0) begin
            active = CNT_W'(1);
        end else if (32'(bcount_reg) > BUCKETS) begin
            active = CNT_W'(BUCKETS);
        end
    end

    assign slot_ok = 32'(slot_reg) < NODES;

    hcm_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_key),
        .divisor   (active),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    hcm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
        .aclk    (aclk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_addr (bkt_reg),
        .rd_data (head_rdata)
    );

    hcm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_keys (
        .aclk    (aclk),
        .wr_en   (node_we),
        .wr_addr (slot_reg[NODE_W-1:0]),
        .wr_data (key_reg),
        .rd_addr (cur_reg),
        .rd_data (key_rdata)
    );

    hcm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_vals (
        .aclk    (aclk),
        .wr_en   (node_we),
        .wr_addr (slot_reg[NODE_W-1:0]),
        .wr_data (val_reg),
        .rd_addr (cur_reg),
        .rd_data (val_rdata)
    );

    hcm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_links (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (cur_reg),
        .rd_data (link_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        slot_next   = slot_reg;
        bkt_next    = bkt_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        nwr_next    = 1'b0;
        rfound_next = rfound_reg;
        rval_next   = rval_reg;
        rused_next  = rused_reg;
        mvalid_next = mvalid_reg;
        mfound_next = mfound_reg;
        mval_next   = mval_reg;
        mused_next  = mused_reg;
        div_start   = 1'b0;
        head_we     = 1'b0;
        head_waddr  = bkt_reg;
        head_wdata  = {1'b1, slot_reg[NODE_W-1:0]};
        link_we     = 1'b0;
        link_waddr  = slot_reg[NODE_W-1:0];
        link_wdata  = '0;
        s_ready     = (state_reg == S_IDLE);

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        // deferred node write after an append
        if (nwr_reg) begin
            link_we = 1'b1;
        end

        case (state_reg)
            S_CLR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BUCKET_W'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_command;
                    key_next    = s_key;
                    val_next    = s_value;
                    slot_next   = s_node_slot;
                    bkt_next    = s_bucket;
                    rfound_next = 1'b0;
                    rval_next   = '0;
                    rused_next  = (s_command == CMD_INSERT) ? s_node_slot : 10'd0;
                    case (s_command)
                        CMD_INSERT, CMD_GET: begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        CMD_CHECK: state_next = S_HEAD;
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    bkt_next   = div_rem[BUCKET_W-1:0];
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                state_next = S_ROUTE;
            end
            S_ROUTE: begin
                steps_next = '0;
                if (cmd_reg == CMD_CHECK) begin
                    rfound_next = ({1'b0, bkt_reg} < active) && head_rdata[NODE_W];
                    state_next  = S_FIN;
                end else if (cmd_reg == CMD_INSERT && !slot_ok) begin
                    state_next = S_FIN;
                end else if (!head_rdata[NODE_W]) begin
                    if (cmd_reg == CMD_INSERT) begin
                        head_we     = 1'b1;
                        nwr_next    = 1'b1;
                        rfound_next = 1'b1;
                    end
                    state_next = S_FIN;
                end else begin
                    cur_next   = head_rdata[NODE_W-1:0];
                    state_next = S_NRD;
                end
            end
            S_NRD: begin
                state_next = S_NEV;
            end
            S_NEV: begin
                if (cmd_reg == CMD_GET) begin
                    if (key_rdata == key_reg) begin
                        rfound_next = 1'b1;
                        rval_next   = val_rdata;
                        state_next  = S_FIN;
                    end else if (!link_rdata[NODE_W] ||
                                 32'(steps_reg) + 1 >= NODES) begin
                        state_next = S_FIN;
                    end else begin
                        steps_next = steps_reg + 1'b1;
                        cur_next   = link_rdata[NODE_W-1:0];
                        state_next = S_NRD;
                    end
                end else begin
                    if (link_rdata[NODE_W] && 32'(steps_reg) < NODES) begin
                        steps_next = steps_reg + 1'b1;
                        cur_next   = link_rdata[NODE_W-1:0];
                        state_next = S_NRD;
                    end else begin
                        state_next = S_TWR;
                    end
                end
            end
            S_TWR: begin
                link_we     = 1'b1;
                link_waddr  = cur_reg;
                link_wdata  = {1'b1, slot_reg[NODE_W-1:0]};
                nwr_next    = 1'b1;
                rfound_next = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (!nwr_reg && (!mvalid_reg || m_ready)) begin
                    mvalid_next = 1'b1;
                    mfound_next = rfound_reg;
                    mval_next   = rval_reg;
                    mused_next  = rused_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign node_we = nwr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            bcount_reg <= CNT_W'(1024);
            nwr_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            nwr_reg    <= nwr_next;
            mvalid_reg <= mvalid_next;
            if (cfg_wr_en) begin
                bcount_reg <= cfg_wr_data;
            end
        end
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        bkt_reg    <= bkt_next;
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        rfound_reg <= rfound_next;
        rval_reg   <= rval_next;
        rused_reg  <= rused_next;
        mfound_reg <= mfound_next;
        mval_reg   <= mval_next;
        mused_reg  <= mused_next;
    end

    assign m_valid      = mvalid_reg;
    assign m_found      = mfound_reg;
    assign m_read_value = mval_reg;
    assign m_node_used  = mused_reg;

`ifndef SYNTH
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == S_DIV)
        else $error("remainder unit busy outside divide state");
    a_clear_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> state_reg == S_CLR)
        else $error("head clearing pass not started after reset");
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside finish state");
`endif
endmodule
`default_nettype wire

>>> hdl/hcm_ram.sv
// ----------------------------------------------------------------------------
// hcm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module hcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hdl/hcm_mod_unit.sv
// ----------------------------------------------------------------------------
// hcm_mod_unit
// Bit-serial restoring remainder of a 64-bit key by the bucket count.
// ----------------------------------------------------------------------------
`default_nettype none
module hcm_mod_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire hcm_pkg::word_t            dividend,
    input  wire logic [hcm_pkg::CNT_W-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [hcm_pkg::CNT_W-1:0]      remainder
);
    import hcm_pkg::*;

    localparam int ITER_W = $clog2(KEY_W + 1);

    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    word_t             dq_reg, dq_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dq_reg[KEY_W-1]};
        if (start) begin
            cnt_next  = ITER_W'(KEY_W);
            busy_next = 1'b1;
            dq_next   = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[CNT_W-1:0];
            dq_next  = {dq_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained hash map: a queue-fed driver pushes
// insert, get, check and unused commands while a shadow hash table predicts each
// result; a monitor checks every returned transaction field by field.
// ----------------------------------------------------------------------------
module tb;
    import hcm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 10000000;
    localparam int unsigned LONG_HOLD   = 3000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] value;
        logic [9:0]  slot;
        logic [9:0]  bucket;
    } command_t;

    typedef struct packed {
        logic        found;
        logic [63:0] read_value;
        logic [9:0]  node_used;
    } answer_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_command = '0;
    logic signed [63:0]  s_key = '0;
    logic signed [63:0]  s_value = '0;
    logic [9:0]          s_node_slot = '0;
    logic [9:0]          s_bucket = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_found;
    logic signed [63:0]  m_read_value;
    logic [9:0]          m_node_used;

    chained_hash_map_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_key(s_key), .s_value(s_value), .s_node_slot(s_node_slot),
        .s_bucket(s_bucket),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_read_value(m_read_value), .m_node_used(m_node_used)
    );

    // shadow table
    int unsigned  shadow_count = BUCKETS;
    bit           head_ok [BUCKETS];
    int unsigned  head_at [BUCKETS];
    logic [63:0]  nkey    [NODES];
    logic [63:0]  nval    [NODES];
    bit           link_ok [NODES];
    int unsigned  link_at [NODES];

    command_t     pending_cmds[$];
    answer_t      expected_answers[$];
    logic [63:0]  stored_keys[$];
    int unsigned  next_slot = 0;
    int unsigned  snd_idle = 0, rcv_idle = 0;
    bit           tx_hold = 1'b0, rx_hold_req = 1'b0, rx_hold_done = 1'b0;
    int unsigned  rx_hold_left = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;

    function automatic int unsigned live_buckets();
        if (shadow_count == 0) return 1;
        if (shadow_count > BUCKETS) return BUCKETS;
        return shadow_count;
    endfunction

    function automatic answer_t map_apply(command_t c);
        answer_t     r;
        int unsigned b, cur, steps;
        r = '0;
        case (c.cmd)
            CMD_INSERT: begin
                r.node_used = c.slot;
                b = int'(c.key % 64'(live_buckets()));
                if (!head_ok[b]) begin
                    head_ok[b] = 1'b1;
                    head_at[b] = c.slot;
                end else begin
                    cur = head_at[b];
                    steps = 0;
                    while (link_ok[cur] && steps < NODES) begin
                        cur = link_at[cur];
                        steps++;
                    end
                    link_ok[cur] = 1'b1;
                    link_at[cur] = c.slot;
                end
                nkey[c.slot] = c.key;
                nval[c.slot] = c.value;
                link_ok[c.slot] = 1'b0;
                link_at[c.slot] = 0;
                r.found = 1'b1;
            end
            CMD_GET: begin
                b = int'(c.key % 64'(live_buckets()));
                if (head_ok[b]) begin
                    cur = head_at[b];
                    steps = 0;
                    forever begin
                        if (nkey[cur] == c.key) begin
                            r.found = 1'b1;
                            r.read_value = nval[cur];
                            break;
                        end
                        steps++;
                        if (!link_ok[cur] || steps >= NODES) break;
                        cur = link_at[cur];
                    end
                end
            end
            CMD_CHECK: r.found = (c.bucket < live_buckets()) && head_ok[c.bucket];
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand_key(bit narrow);
        if (narrow) return 64'($urandom_range(0, 4000));
        return {$urandom, $urandom};
    endfunction

    function automatic command_t rand_command();
        command_t    c;
        int unsigned p;
        c.cmd    = CMD_INSERT;
        c.key    = rand_key(1'($urandom_range(0, 1)));
        c.value  = {$urandom, $urandom};
        c.slot   = 10'($urandom_range(0, 1023));
        c.bucket = 10'($urandom_range(0, 1023));
        p = $urandom_range(0, 99);
        if (p < 40) begin
            if ($urandom_range(0, 9) != 0) begin
                c.slot = 10'(next_slot);
                next_slot = (next_slot + 1) % NODES;
            end
            if (stored_keys.size() > 0 && $urandom_range(0, 9) == 0)
                c.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            stored_keys.push_back(c.key);
        end else if (p < 80) begin
            c.cmd = CMD_GET;
            if (stored_keys.size() > 0 && $urandom_range(0, 9) < 7)
                c.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end else if (p < 95) begin
            c.cmd = CMD_CHECK;
            if ($urandom_range(0, 1)) c.bucket = 10'($urandom_range(0, 15));
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    function automatic void push_cmd(logic [1:0] cmd, logic [63:0] key, logic [63:0] value,
                                     logic [9:0] slot, logic [9:0] bucket);
        command_t c;
        c = '{cmd, key, value, slot, bucket};
        pending_cmds.push_back(c);
    endfunction

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        command_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cmds.size() > 0 && !tx_hold && $urandom_range(0, 99) >= snd_idle) begin
                c = pending_cmds.pop_front();
                s_valid     <= 1'b1;
                s_command   <= c.cmd;
                s_key       <= c.key;
                s_value     <= c.value;
                s_node_slot <= c.slot;
                s_bucket    <= c.bucket;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, with one long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_hold_req && !rx_hold_done) begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // prediction on accepted commands, checking on accepted answers
    always @(posedge aclk) begin
        command_t c;
        answer_t  got, exp;
        if (aresetn && s_valid && s_ready) begin
            c = '{s_command, s_key, s_value, s_node_slot, s_bucket};
            expected_answers.push_back(map_apply(c));
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_found, m_read_value, m_node_used};
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: found=%0b value=%h node=%0d",
                             got.found, got.read_value, got.node_used);
            end else begin
                exp = expected_answers.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp found=%0b value=%h node=%0d, ",
                                  "got found=%0b value=%h node=%0d"},
                                 exp.found, exp.read_value, exp.node_used,
                                 got.found, got.read_value, got.node_used);
                end
            end
        end
    end

    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_answers.size() > 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_buckets(int unsigned n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(n);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_count = n & 11'h7FF;
        @(posedge aclk);
    endtask

    task automatic run_random(int unsigned n);
        repeat (n) pending_cmds.push_back(rand_command());
    endtask

    initial begin
        for (int i = 0; i < BUCKETS; i++) head_ok[i] = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, duplicates, misses, bucket bounds
        set_buckets(2047);
        push_cmd(CMD_CHECK, '0, '0, '0, 10'd0);
        push_cmd(CMD_GET, 64'd5, '0, '0, '0);
        push_cmd(CMD_INSERT, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 10'd0, '0);
        push_cmd(CMD_INSERT, '1, 64'h8000_0000_0000_0000, 10'd1023, '0);
        push_cmd(CMD_INSERT, 64'h8000_0000_0000_0000, '1, 10'd1, '0);
        push_cmd(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 10'd2, 10'h3FF);
        push_cmd(CMD_INSERT, 64'd1024, 64'd11, 10'd3, '0);
        push_cmd(CMD_INSERT, 64'd1024, 64'd22, 10'd4, '0);
        push_cmd(CMD_GET, 64'd0, '0, '0, '0);
        push_cmd(CMD_GET, '1, '0, '0, '0);
        push_cmd(CMD_GET, 64'h8000_0000_0000_0000, '0, '0, '0);
        push_cmd(CMD_GET, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0);
        push_cmd(CMD_GET, 64'd1024, '0, '0, '0);
        push_cmd(CMD_GET, 64'd2048, '0, '0, '0);
        push_cmd(CMD_CHECK, '0, '0, '0, 10'd1023);
        push_cmd(CMD_CHECK, '0, '0, '0, 10'd5);
        push_cmd(CMD_UNUSED, '1, '1, 10'h3FF, 10'h3FF);
        push_cmd(CMD_INSERT, 64'd2048, 64'd33, 10'd3, '0);
        push_cmd(CMD_GET, 64'd1024, '0, '0, '0);
        push_cmd(CMD_GET, 64'd2048, '0, '0, '0);
        next_slot = 5;

        // single bucket, written as zero and as one
        set_buckets(0);
        push_cmd(CMD_CHECK, '0, '0, '0, 10'd1);
        run_random(10);
        set_buckets(1);
        push_cmd(CMD_CHECK, '0, '0, '0, 10'd0);
        run_random(10);

        // sender sparse, receiver mostly stalled; long receiver hold-off
        set_buckets(7);
        snd_idle = 37;
        rcv_idle = 78;
        rx_hold_req = 1'b1;
        run_random(100);
        drain();
        tx_hold = 1'b1;
        run_random(10);
        while (s_valid || expected_answers.size() > 0) @(negedge aclk);
        tx_hold = 1'b0;
        run_random(90);

        set_buckets(1023);
        snd_idle = 78;
        rcv_idle = 37;
        run_random(180);

        set_buckets(1024);
        snd_idle = 0;
        rcv_idle = 0;
        run_random(180);

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
